/* hw/rtl/wrf_pkg.sv */
// shared types, constants and helpers of the window rank filter
`timescale 1ns / 1ps
`default_nettype none
package wrf_pkg;

  localparam int MAX_WINDOW = 15;
  localparam int LINE_COLS  = 1024;
  localparam int LINE_DEPTH = MAX_WINDOW * LINE_COLS;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int FIFO_DEPTH = 2;

  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int WIN_W  = 4;
  localparam int PROD_W = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [1:0] RANK_MIN = 2'd0;
  localparam logic [1:0] RANK_MED = 2'd1;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_pixel;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic [WIN_W-1:0] win;
    logic [7:0]       target;
    logic             contour;
    logic             last;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_ROW, BK_COL, BK_DRAIN, BK_DECIDE,
    BK_CPROD, BK_CREAD, BK_CWAIT, BK_RESULT
  } bk_state_t;

  // raster index modulo 15*1024: the upper part mod 15 by summing hex digits
  function automatic logic [ADDR_W-1:0] line_addr(input logic [PROD_W-1:0] x);
    logic [11:0] q;
    logic [5:0]  s1;
    logic [4:0]  s2;
    logic [3:0]  r;
    q  = x[PROD_W-1:10];
    s1 = {2'b0, q[11:8]} + {2'b0, q[7:4]} + {2'b0, q[3:0]};
    s2 = {3'b0, s1[5:4]} + {1'b0, s1[3:0]};
    r  = (s2 >= 5'd15) ? 4'(s2 - 5'd15) : s2[3:0];
    return {r, x[9:0]};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/wrf_fifo.sv */
// small register fifo used for jobs and for results
`timescale 1ns / 1ps
`default_nettype none
module wrf_fifo
  import wrf_pkg::*;
#(
  parameter int WIDTH = $bits(out_item_t),
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = store_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

/* hw/rtl/wrf_line_mem.sv */
// line store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module wrf_line_mem
  import wrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);
  logic [7:0] mem_r [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem_r[rd_addr];
  end
endmodule
`default_nettype wire

/* hw/rtl/wrf_front.sv */
// front end: config registers, pixel intake, raster positions, job issue
`timescale 1ns / 1ps
`default_nettype none
module wrf_front
  import wrf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire in_item_t              in_data,
  input  wire logic                  back_busy,
  input  wire logic                  job_empty,
  output logic                       job_push,
  output job_t                       job,
  output logic                       wr_en,
  output logic      [ADDR_W-1:0]     wr_addr,
  output logic      [7:0]            wr_data
);
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [WIN_W-1:0] win_r;
  logic [1:0]       rank_r;
  logic             mode_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [COL_W-1:0] in_col_r, out_col_r;
  logic             done_r;
  logic [ADDR_W-1:0] ptr_r;

  logic [WID_W-1:0] w_eff, wmax;
  logic [HGT_W-1:0] h_eff, hmax;
  logic [WIN_W-1:0] d_eff, ahead;
  logic [7:0]       n_cnt, target;
  logic             acc, pix;
  logic [WID_W-1:0] col1;
  logic [HGT_W-1:0] row1;
  logic [ROW_W-1:0] row_nxt;
  logic [COL_W-1:0] col_nxt;
  logic             done_nxt, wrap;
  logic [HGT_W-1:0] need_r;
  logic [WID_W-1:0] need_c;
  logic [HGT_W-1:0] row_ahead;
  logic [WID_W-1:0] col_ahead;
  logic             due, last;
  logic             cfg_wr, geom_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign geom_wr   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                                cfg_index == REG_WINDOW);

  // one item at a time: the back end owns the line store while it works
  assign in_full = back_busy || !job_empty;
  assign acc     = in_push && !in_full;
  assign pix     = acc && (in_data.operation == OP_PIXEL) && !done_r;

  always_comb begin
    if (width_r == '0) w_eff = WID_W'(1);
    else if (width_r > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == '0) h_eff = HGT_W'(1);
    else if (height_r > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else h_eff = height_r;
    if (win_r == '0) d_eff = WIN_W'(1);
    else if (win_r > WIN_W'(MAX_WINDOW)) d_eff = WIN_W'(MAX_WINDOW);
    else d_eff = win_r;
  end

  assign wmax  = w_eff - 1'b1;
  assign hmax  = h_eff - 1'b1;
  assign ahead = d_eff - 1'b1 - (d_eff >> 1);
  assign n_cnt = {4'b0, d_eff} * {4'b0, d_eff};

  always_comb begin
    case (rank_r)
      RANK_MIN: target = '0;
      RANK_MED: target = n_cnt >> 1;
      default:  target = n_cnt - 1'b1;
    endcase
  end

  // input position after this item
  always_comb begin
    col1     = {1'b0, in_col_r} + 1'b1;
    row1     = {1'b0, in_row_r} + 1'b1;
    row_nxt  = in_row_r;
    col_nxt  = in_col_r;
    done_nxt = done_r;
    wrap     = 1'b0;
    if (pix) begin
      if (col1 >= w_eff) begin
        col_nxt = '0;
        if (row1 >= h_eff) begin
          row_nxt  = '0;
          done_nxt = 1'b1;
          wrap     = 1'b1;
        end else begin
          row_nxt = row1[ROW_W-1:0];
        end
      end else begin
        col_nxt = col1[COL_W-1:0];
      end
    end
  end

  assign row_ahead = {1'b0, out_row_r} + {{(HGT_W-WIN_W){1'b0}}, ahead};
  assign col_ahead = {1'b0, out_col_r} + {{(WID_W-WIN_W){1'b0}}, ahead};
  assign need_r    = (row_ahead > hmax) ? hmax : row_ahead;
  assign need_c    = (col_ahead > wmax) ? wmax : col_ahead;
  assign due       = acc && (done_nxt || ({1'b0, row_nxt} > need_r) ||
                     ({1'b0, row_nxt} == need_r && {1'b0, col_nxt} > need_c));
  assign last      = ({1'b0, out_row_r} == hmax) && ({1'b0, out_col_r} == wmax);

  assign job_push    = due;
  assign job.row     = out_row_r;
  assign job.col     = out_col_r;
  assign job.width   = w_eff;
  assign job.height  = h_eff;
  assign job.win     = d_eff;
  assign job.target  = target;
  assign job.contour = mode_r;
  assign job.last    = last;

  assign wr_en   = pix;
  assign wr_addr = ptr_r;
  assign wr_data = in_data.pixel_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WID_W'(256);
      height_r  <= HGT_W'(256);
      win_r     <= WIN_W'(3);
      rank_r    <= RANK_MIN;
      mode_r    <= 1'b0;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      done_r    <= 1'b0;
      ptr_r     <= '0;
    end else begin
      // new frame on a geometry write or after the frame's last result
      if (geom_wr || (due && last)) begin
        in_row_r  <= '0;
        in_col_r  <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
        done_r    <= 1'b0;
        ptr_r     <= '0;
      end else begin
        in_row_r <= row_nxt;
        in_col_r <= col_nxt;
        done_r   <= done_nxt;
        if (pix) begin
          if (wrap) ptr_r <= '0;
          else ptr_r <= (ptr_r == ADDR_W'(LINE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
        end
        if (due) begin
          if ({1'b0, out_col_r} == wmax) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
      if (cfg_wr) begin
        case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
          REG_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
          REG_WINDOW: win_r    <= cfg_data[WIN_W-1:0];
          REG_RANK:   rank_r   <= cfg_data[1:0];
          REG_MODE:   mode_r   <= cfg_data[0];
          default:    ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/wrf_back.sv */
// back end: bitwise rank selection over the window, one pass per result bit
`timescale 1ns / 1ps
`default_nettype none
module wrf_back
  import wrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_empty,
  input  wire job_t              job_in,
  output logic                   job_pop,
  output logic                   busy,
  output logic                   rd_en,
  output logic      [ADDR_W-1:0] rd_addr,
  input  wire logic [7:0]        rd_data,
  input  wire logic              out_full,
  output logic                   out_push,
  output out_item_t              out_item
);
  bk_state_t state_r, state_nxt;
  job_t              job_r;
  logic [WIN_W-1:0]  k_r, m_r;
  logic [2:0]        bit_r;
  logic [7:0]        prefix_r, target_r, cnt_r, result_r;
  logic [PROD_W-1:0] prod_r;
  logic              rd_vld_r;

  logic [WIN_W-1:0]  half, dmax;
  logic [HGT_W-1:0]  rsum, rdiff, hmax;
  logic [WID_W-1:0]  csum, cdiff, wmax;
  logic [ROW_W-1:0]  rr;
  logic [COL_W-1:0]  cc, col_sel;
  logic [ROW_W-1:0]  row_sel;
  logic [ROW_W+WID_W-1:0] prod_full;
  logic [3:0]        sh;
  logic [8:0]        mask9;
  logic              hit;
  logic [7:0]        prefix_set;
  logic              take_one;

  assign half = job_r.win >> 1;
  assign dmax = job_r.win - 1'b1;
  assign hmax = job_r.height - 1'b1;
  assign wmax = job_r.width - 1'b1;

  // clamped window coordinates
  always_comb begin
    rsum  = {1'b0, job_r.row} + {{(HGT_W-WIN_W){1'b0}}, k_r};
    rdiff = rsum - {{(HGT_W-WIN_W){1'b0}}, half};
    if (rsum < {{(HGT_W-WIN_W){1'b0}}, half}) rr = '0;
    else if (rdiff > hmax) rr = hmax[ROW_W-1:0];
    else rr = rdiff[ROW_W-1:0];
    csum  = {1'b0, job_r.col} + {{(WID_W-WIN_W){1'b0}}, m_r};
    cdiff = csum - {{(WID_W-WIN_W){1'b0}}, half};
    if (csum < {{(WID_W-WIN_W){1'b0}}, half}) cc = '0;
    else if (cdiff > wmax) cc = wmax[COL_W-1:0];
    else cc = cdiff[COL_W-1:0];
  end

  assign row_sel   = (state_r == BK_CPROD) ? job_r.row : rr;
  assign col_sel   = (state_r == BK_CREAD) ? job_r.col : cc;
  assign prod_full = row_sel * job_r.width;
  assign rd_addr   = line_addr(prod_r + {{(PROD_W-COL_W){1'b0}}, col_sel});

  // values whose upper bits match the prefix and whose current bit is zero
  assign sh       = {1'b0, bit_r} + 4'd1;
  assign mask9    = 9'h1FF << sh;
  assign hit      = rd_vld_r && (((rd_data ^ prefix_r) & mask9[7:0]) == 8'd0) &&
                    !rd_data[bit_r];
  assign take_one = (target_r >= cnt_r);
  always_comb begin
    prefix_set = prefix_r;
    prefix_set[bit_r] = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (!job_empty) state_nxt = BK_ROW;
      BK_ROW:    state_nxt = BK_COL;
      BK_COL:    if (m_r == dmax) state_nxt = (k_r == dmax) ? BK_DRAIN : BK_ROW;
      BK_DRAIN:  state_nxt = BK_DECIDE;
      BK_DECIDE: begin
        if (bit_r != 3'd0) state_nxt = BK_ROW;
        else state_nxt = job_r.contour ? BK_CPROD : BK_RESULT;
      end
      BK_CPROD:  state_nxt = BK_CREAD;
      BK_CREAD:  state_nxt = BK_CWAIT;
      BK_CWAIT:  state_nxt = BK_RESULT;
      BK_RESULT: if (!out_full) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = 1'b0;
    rd_en    = 1'b0;
    out_push = 1'b0;
    busy     = 1'b1;
    unique case (state_r)
      BK_IDLE: begin
        busy    = 1'b0;
        job_pop = !job_empty;
      end
      BK_COL, BK_CREAD: rd_en = 1'b1;
      BK_RESULT: out_push = !out_full;
      default: ;
    endcase
  end

  assign out_item.result_pixel = result_r;
  assign out_item.frame_last   = job_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == BK_COL);
    end
  end

  always_ff @(posedge clk) begin
    if (hit) cnt_r <= cnt_r + 1'b1;
    case (state_r)
      BK_IDLE: begin
        job_r    <= job_in;
        k_r      <= '0;
        m_r      <= '0;
        bit_r    <= 3'd7;
        prefix_r <= '0;
        target_r <= job_in.target;
        cnt_r    <= '0;
      end
      BK_ROW, BK_CPROD: begin
        prod_r <= prod_full[PROD_W-1:0];
        m_r    <= '0;
      end
      BK_COL: begin
        if (m_r == dmax) k_r <= k_r + 1'b1;
        else m_r <= m_r + 1'b1;
      end
      BK_DECIDE: begin
        if (take_one) begin
          prefix_r <= prefix_set;
          target_r <= target_r - cnt_r;
          result_r <= prefix_set;
        end else begin
          result_r <= prefix_r;
        end
        cnt_r <= '0;
        k_r   <= '0;
        bit_r <= bit_r - 1'b1;
      end
      BK_CWAIT: result_r <= (rd_data > result_r) ? rd_data - result_r : 8'd0;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/window_rank_filter.sv */
// top level of the window rank filter
// Streaming min / median / max filter over a d-by-d window of 8-bit grey
// pixels in raster order, with replicated borders and an optional contour
// mode (centre minus rank value, floored at zero).
// Channels: in_push/in_full carries a pixel push or a flush tick; out_pop/
// out_empty gives results oldest first, frame_last marks the frame's last
// pixel; cfg_valid/cfg_ready writes one register per transfer (always ready).
// Writing width, height or window size restarts the frame.
// Each accepted item is held off (in_full) until the back end has finished
// the result it causes. A result is found bit by bit: eight passes over the
// d*d window values through the single read port of the line store; an item
// that yields no result needs no pass. Results wait in a two-entry output
// queue; when the receiver stalls and the queue is full, the back end holds
// its result and in_full stays high. Reset (synchronous, active low) restores
// register defaults and empties both queues; the line store is not cleared
// and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module window_rank_filter
  import wrf_pkg::*;
#(
  parameter int JOB_DEPTH = FIFO_DEPTH,
  parameter int OUT_DEPTH = FIFO_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire in_item_t              in_data,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  job_t      job_w, job_q;
  logic      job_push, job_pop, job_full, job_empty;
  logic      back_busy;
  logic      wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0] wr_data, rd_data;
  out_item_t res_w;
  logic      res_push, res_full;

  wrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .back_busy (back_busy),
    .job_empty (job_empty),
    .job_push  (job_push),
    .job       (job_w),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  wrf_fifo #(.WIDTH($bits(job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_w),
    .full    (job_full),
    .pop     (job_pop),
    .rd_data (job_q),
    .empty   (job_empty)
  );

  wrf_line_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_in    (job_q),
    .job_pop   (job_pop),
    .busy      (back_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_item  (res_w)
  );

  wrf_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_w),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

  // the front end never pushes while a job is queued, so this stays low
  logic unused_full;
  assign unused_full = job_full;
endmodule
`default_nettype wire

/* hw/rtl/wrf_checker.sv */
// port level checks of the window rank filter and their bind
`timescale 1ns / 1ps
`default_nettype none
module wrf_checker
  import wrf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire logic      out_empty,
  input wire logic      out_pop,
  input wire out_item_t out_data
);
  // reset leaves both sides open and nothing waiting
  a_reset: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("not idle after reset");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

  // results only come from the back end, which keeps the input closed
  a_source: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(in_full))
    else $error("result appeared while input open");
endmodule

bind window_rank_filter wrf_checker u_wrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
`default_nettype wire

/* verif/window_rank_filter_tb.sv */
// self-checking testbench of the window rank filter
`timescale 1ns / 1ps
module window_rank_filter_tb;
  import wrf_pkg::*;

  localparam logic [1:0] RANK_MAX   = 2'd2;
  localparam logic [1:0] RANK_THREE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam int SETTLE = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 600;

  logic clk, rst_n;
  logic in_push, in_full;
  in_item_t in_data;
  logic out_empty, out_pop;
  out_item_t out_data;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  window_rank_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0] px_store [LINE_DEPTH];
  int px_in_row, px_in_col, px_out_row, px_out_col;
  bit px_done;
  int frames_done;
  int reg_width, reg_height, reg_window, reg_rank, reg_mode;

  out_item_t pending_pixels[$];
  int err_count, items_sent, results_seen, writes_done;
  bit quiet;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_width();
    if (reg_width == 0) return 1;
    return reg_width > MAX_WIDTH ? MAX_WIDTH : reg_width;
  endfunction

  function automatic int eff_height();
    if (reg_height == 0) return 1;
    return reg_height > MAX_HEIGHT ? MAX_HEIGHT : reg_height;
  endfunction

  function automatic int eff_window();
    if (reg_window == 0) return 1;
    return reg_window > MAX_WINDOW ? MAX_WINDOW : reg_window;
  endfunction

  function automatic void restart_frame();
    px_in_row = 0;
    px_in_col = 0;
    px_out_row = 0;
    px_out_col = 0;
    px_done = 0;
  endfunction

  function automatic int clamp(int v, int hi);
    if (v < 0) return 0;
    return v > hi ? hi : v;
  endfunction

  // rank value of the window around the next output position
  function automatic int window_rank_of(int w, int h, int d);
    int hist[256];
    int half, target, cum, rr, cc;
    half = d / 2;
    cum = 0;
    foreach (hist[i]) hist[i] = 0;
    for (int k = 0; k < d; k++) begin
      rr = clamp(px_out_row - half + k, h - 1);
      for (int m = 0; m < d; m++) begin
        cc = clamp(px_out_col - half + m, w - 1);
        hist[px_store[(rr * w + cc) % LINE_DEPTH]]++;
      end
    end
    if (reg_rank == RANK_MIN) target = 0;
    else if (reg_rank == RANK_MED) target = d * d / 2;
    else target = d * d - 1;
    for (int v = 0; v < 256; v++) begin
      cum += hist[v];
      if (cum > target) return v;
    end
    return 255;
  endfunction

  // advance the predictor by one accepted item, queue the result it causes
  function automatic void filter_pixel(logic op, logic [7:0] pix);
    int w, h, d, ahead, need_r, need_c, rank, centre, res;
    bit last;
    out_item_t r;
    w = eff_width();
    h = eff_height();
    d = eff_window();
    ahead = d - 1 - d / 2;
    if (op == OP_PIXEL && !px_done) begin
      px_store[(px_in_row * w + px_in_col) % LINE_DEPTH] = pix;
      px_in_col++;
      if (px_in_col >= w) begin
        px_in_col = 0;
        px_in_row++;
        if (px_in_row >= h) begin
          px_in_row = 0;
          px_done = 1;
        end
      end
    end
    need_r = px_out_row + ahead > h - 1 ? h - 1 : px_out_row + ahead;
    need_c = px_out_col + ahead > w - 1 ? w - 1 : px_out_col + ahead;
    if (!(px_done || px_in_row > need_r || (px_in_row == need_r && px_in_col > need_c)))
      return;
    rank = window_rank_of(w, h, d);
    if (reg_mode != 0) begin
      centre = px_store[(px_out_row * w + px_out_col) % LINE_DEPTH];
      res = centre > rank ? centre - rank : 0;
    end else begin
      res = rank;
    end
    last = (px_out_row == h - 1) && (px_out_col == w - 1);
    r.result_pixel = res[7:0];
    r.frame_last = last;
    pending_pixels.push_back(r);
    if (last) begin
      restart_frame();
      frames_done++;
    end else begin
      px_out_col++;
      if (px_out_col >= w) begin
        px_out_col = 0;
        px_out_row++;
      end
    end
  endfunction

  // one item transfer on the input channel; called at a falling edge
  task automatic send_item(input logic op, input logic [7:0] pix);
    if (!quiet && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 5)) @(negedge clk);
    in_push = 1'b1;
    in_data.operation = op;
    in_data.pixel_value = pix;
    do @(posedge clk); while (in_full);
    filter_pixel(op, pix);
    items_sent++;
    @(negedge clk);
    in_push = 1'b0;
  endtask

  // register write once every expected result is out and the block has settled
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] v;
    v = value[CFG_DATA_W-1:0];
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  begin reg_width = v & 13'h7ff; restart_frame(); end
      REG_HEIGHT: begin reg_height = v & 13'h1fff; restart_frame(); end
      REG_WINDOW: begin reg_window = v & 13'hf; restart_frame(); end
      REG_RANK:   reg_rank = v & 13'h3;
      REG_MODE:   reg_mode = v & 13'h1;
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup(input int w, input int h, input int d, input int r, input int m);
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
    set_reg(REG_WINDOW, d);
    set_reg(REG_RANK, r);
    set_reg(REG_MODE, m);
  endtask

  // feed one frame (or the first cut items of it); noisy mixes in flush ticks
  // mid-frame and pushes after all pixels are in
  task automatic run_frame(input bit noisy, input bit extremes, input int cut);
    int start, sent;
    logic op;
    logic [7:0] pix;
    start = frames_done;
    sent = 0;
    while (frames_done == start && (cut == 0 || sent < cut)) begin
      if (px_done) op = (noisy && $urandom_range(0, 4) == 0) ? OP_PIXEL : OP_FLUSH;
      else op = (noisy && $urandom_range(0, 9) == 0) ? OP_FLUSH : OP_PIXEL;
      pix = extremes ? ($urandom_range(0, 1) ? 8'hff : 8'h00) : 8'($urandom_range(0, 255));
      send_item(op, pix);
      sent++;
    end
  endtask

  task automatic test_reset_defaults();
    send_item(OP_FLUSH, 8'h00);  // nothing pending yet
    send_item(OP_PIXEL, 8'hff);
    send_item(OP_PIXEL, 8'h00);
  endtask

  task automatic test_extremes();
    setup(2, 2, 3, RANK_MIN, 0);
    run_frame(0, 1, 0);
    setup(1, 1, 1, RANK_MAX, 1);
    run_frame(0, 1, 0);
    setup(3, 1, 15, RANK_MED, 1);
    run_frame(0, 0, 0);
  endtask

  task automatic test_odd_registers();
    setup(0, 0, 0, RANK_THREE, 0);  // zero geometry acts as one
    run_frame(0, 0, 0);
    set_reg(REG_UNUSED, 13'h1fff);
    set_reg(REG_WIDTH, 2047);       // clamps to the widest row
    set_reg(REG_HEIGHT, 8191);
    set_reg(REG_WINDOW, 16 + 1);    // upper bits dropped
    run_frame(0, 1, 3);
  endtask

  task automatic test_push_after_done();
    setup(2, 2, 3, RANK_MED, 0);
    repeat (4) send_item(OP_PIXEL, 8'($urandom_range(0, 255)));
    repeat (3) send_item(OP_PIXEL, 8'($urandom_range(0, 255)));
    send_item(OP_FLUSH, 8'h00);     // frame over, nothing pending
  endtask

  task automatic test_backpressure();
    setup(8, 4, 3, RANK_MAX, 0);
    hold_cycles = 3000;
    run_frame(0, 0, 0);
  endtask

  task automatic test_random();
    int w, h, d;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) begin
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 3);
        d = $urandom_range(6, 15);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
        d = $urandom_range(1, 5);
      end
      setup(w, h, d, $urandom_range(0, 3), $urandom_range(0, 1));
      run_frame(1, $urandom_range(0, 5) == 0, $urandom_range(0, 9) == 0 ? w * h / 2 + 1 : 0);
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1;
    setup(6, 5, 3, RANK_MED, 0);
    run_frame(0, 0, 0);
    setup(5, 4, 2, RANK_MIN, 1);
    run_frame(0, 0, 0);
  endtask

  // result side: random stall bursts, a long hold when asked
  initial begin
    int stall;
    stall = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_pop = 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_pop = 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_pop = 1'b0;
        stall = $urandom_range(0, 4);
      end else begin
        out_pop = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data);
        err_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.result_pixel !== want.result_pixel) begin
          $error("result_pixel expected %0d actual %0d", want.result_pixel,
                 out_data.result_pixel);
          err_count++;
        end
        if (out_data.frame_last !== want.frame_last) begin
          $error("frame_last expected %0d actual %0d", want.frame_last, out_data.frame_last);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    int quiet_run;
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_run = 0;
    else
      quiet_run++;
    if (quiet_run >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("[window_rank_filter] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 0;
    hold_cycles = 0;
    err_count = 0;
    items_sent = 0;
    results_seen = 0;
    writes_done = 0;
    frames_done = 0;
    reg_width = 256;
    reg_height = 256;
    reg_window = 3;
    reg_rank = 0;
    reg_mode = 0;
    restart_frame();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_extremes();
    test_odd_registers();
    test_push_after_done();
    test_backpressure();
    test_random();
    test_quiet_tail();

    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d input items, %0d results, %0d frames, %0d register writes",
             items_sent, results_seen, frames_done, writes_done);
    if (err_count == 0) begin
      $display("[window_rank_filter] OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[window_rank_filter] ERROR");
    end
    $finish;
  end

endmodule
